/* rtl/pendulum_rk4_step_assert.svh */
// Assertion macros for the pendulum RK4 step checker.
`ifndef PENDULUM_RK4_STEP_ASSERT_SVH
`define PENDULUM_RK4_STEP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PRK4_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRK4_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/prk4_pkg.sv */
// Types, constants and helper functions shared by the pendulum RK4 step block.
package prk4_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 24;
    localparam int CFG_W  = 31;
    localparam int SIN_SH = 30 - FRAC_W;

    localparam int MA_W   = 35;
    localparam int MB_W   = 31;
    localparam int MR_W   = 41;
    localparam int DD_W   = 42;
    localparam int DV_W   = 34;
    localparam int ACC_W  = 44;
    localparam int SUM_W  = 36;
    localparam int MCNT_W = $clog2(MB_W);
    localparam int DCNT_W = $clog2(DD_W);

    localparam logic [MR_W-1:0] MR_CAP = MR_W'(1) << (MR_W - 1);

    localparam logic [4:0] SH_ACC  = 5'd24;
    localparam logic [4:0] SH_FULL = 5'd30;
    localparam logic [4:0] SH_HALF = 5'd31;

    localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] PI_Q31 = (PI_Q62 + (64'd1 << 30)) >> 31;
    localparam logic [63:0] PI_Q30 = (PI_Q62 + (64'd1 << 31)) >> 32;
    localparam logic [63:0] PI_Q29 = (PI_Q62 + (64'd1 << 32)) >> 33;
    localparam logic [63:0] PI_Q25 = (PI_Q62 + (64'd1 << 36)) >> 37;
    localparam logic [63:0] PI_Q24 = (PI_Q62 + (64'd1 << 37)) >> 38;

    localparam logic [DV_W-1:0] C_TWO_PI30 = PI_Q31[DV_W-1:0];
    localparam logic [DV_W-1:0] C_PI30     = PI_Q30[DV_W-1:0];
    localparam logic [DV_W-1:0] C_HALF_PI30 = PI_Q29[DV_W-1:0];
    localparam logic [DV_W-1:0] C_TP       = PI_Q25[DV_W-1:0];
    localparam logic [DV_W-1:0] C_PI24     = PI_Q24[DV_W-1:0];
    localparam logic [DV_W-1:0] C_DIV6     = DV_W'(6);
    localparam logic [DD_W-1:0] C_D6_BIAS  = DD_W'(3);
    localparam logic [MB_W-1:0] C_ONE_Q30  = MB_W'(1) << 30;

    localparam int HORNER_N = 5;
    localparam logic [DV_W-1:0] HORNER_DIV [HORNER_N] = '{
        DV_W'(110), DV_W'(72), DV_W'(42), DV_W'(20), DV_W'(6)
    };

    localparam logic signed [ACC_W-1:0] SAT_HI =
        $signed((ACC_W'(1) << (WORD_W - 1)) - ACC_W'(1));
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [ACC_W-1:0] WRAP_OFS =
        $signed(ACC_W'(PI_Q24 + (PI_Q25 << 6)));

    localparam logic [CFG_W-1:0] RST_GRAV  = CFG_W'(164587438);
    localparam logic [CFG_W-1:0] RST_DT    = CFG_W'(17895697);
    localparam logic [CFG_W-1:0] RST_FRIC  = CFG_W'(1073741824);
    localparam logic [CFG_W-1:0] RST_LIMIT = CFG_W'(1677721600);

    typedef enum logic [1:0] {
        REG_GRAV  = 2'd0,
        REG_DT    = 2'd1,
        REG_FRIC  = 2'd2,
        REG_LIMIT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                     req_type;
        logic signed [WORD_W-1:0] new_angle;
        logic signed [WORD_W-1:0] new_speed;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] angle_raw;
        logic signed [WORD_W-1:0] angle_mirrored;
        logic signed [WORD_W-1:0] speed;
    } t_out;

    typedef struct packed {
        logic            start;
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
        logic [4:0]      sh;
        logic            rnd;
    } t_mul_req;

    typedef struct packed {
        logic            start;
        logic [DD_W-1:0] num;
        logic [DV_W-1:0] den;
    } t_div_req;

    function automatic logic signed [ACC_W-1:0] sx44(input logic signed [WORD_W-1:0] v);
        return $signed({{(ACC_W-WORD_W){v[WORD_W-1]}}, v});
    endfunction

    function automatic logic signed [SUM_W-1:0] sx36(input logic signed [WORD_W-1:0] v);
        return $signed({{(SUM_W-WORD_W){v[WORD_W-1]}}, v});
    endfunction

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[WORD_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[WORD_W-1:0];
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] v);
        return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
    endfunction

    function automatic logic [MA_W-1:0] mag36(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] m;
        m = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
        return m[MA_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sgn44(input logic [MR_W-1:0] m, input logic s);
        logic signed [ACC_W-1:0] t;
        t = $signed(ACC_W'(m));
        return s ? -t : t;
    endfunction

endpackage

/* rtl/prk4_mul.sv */
// Bit-serial shift-add multiplier with optional rounding, right shift and magnitude cap.
module prk4_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  prk4_pkg::t_mul_req         i_req,
    output logic                       o_done,
    output logic [prk4_pkg::MR_W-1:0]  o_res
);
    import prk4_pkg::*;

    localparam int P_W = MA_W + MB_W + 1;

    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic [MCNT_W-1:0] r_cnt;
    logic [MA_W-1:0]   r_a;
    logic [MA_W-1:0]   r_hi;
    logic [MB_W-1:0]   r_lo;
    logic [4:0]        r_sh;
    logic              r_rnd;
    logic [MR_W-1:0]   r_res;

    logic [MA_W:0]     sum;
    logic [P_W-1:0]    rnd_c;
    logic [P_W-1:0]    qv;
    logic [MR_W-1:0]   n_res;

    always_comb begin
        sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(MA_W+1){1'b0}});
        rnd_c = r_rnd ? (P_W'(1) << (r_sh - 5'd1)) : {P_W{1'b0}};
        qv    = ({1'b0, r_hi, r_lo} + rnd_c) >> r_sh;
        n_res = (qv > P_W'(MR_CAP)) ? MR_CAP : qv[MR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MCNT_W'(1);
                if (r_cnt == MCNT_W'(MB_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_hi  <= '0;
            r_lo  <= i_req.b;
            r_sh  <= i_req.sh;
            r_rnd <= i_req.rnd;
        end else if (r_busy) begin
            {r_hi, r_lo} <= {sum, r_lo[MB_W-1:1]};
        end
        if (r_fin) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* rtl/prk4_div.sv */
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
module prk4_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  prk4_pkg::t_div_req         i_req,
    output logic                       o_done,
    output logic [prk4_pkg::DD_W-1:0]  o_quo,
    output logic [prk4_pkg::DV_W-1:0]  o_rem
);
    import prk4_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DD_W-1:0]   r_num;
    logic [DV_W-1:0]   r_den;
    logic [DV_W-1:0]   r_rem;

    logic [DV_W:0]     sh;
    logic [DV_W:0]     diff;
    logic              ge;

    always_comb begin
        sh   = {r_rem, r_num[DD_W-1]};
        diff = sh - {1'b0, r_den};
        ge   = (sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DCNT_W'(DD_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DCNT_W'(1);
                if (r_cnt == DCNT_W'(DD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DV_W-1:0] : sh[DV_W-1:0];
            r_num <= {r_num[DD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

/* rtl/pendulum_rk4_step.sv */
// Top level: pendulum RK4 step sequencer with shared serial multiplier and divider.
// One item at a time. A load item goes from idle straight to the done state. In a step
// item every multiply goes bit-serially through the one 31-bit shift-add multiplier and
// every divide and modulo through the one restoring divider; when the angle reduction
// triggers it adds one divide. Four sine evaluations (Taylor series in Horner form, five
// divides each) dominate. Results sit in an output register, so a result may wait while
// the next item is accepted. Configuration writes are taken in any cycle; write them
// only while idle.
module pendulum_rk4_step (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  prk4_pkg::t_in                  i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output prk4_pkg::t_out                 o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [prk4_pkg::CFG_W-1:0]     i_cfg_data
);
    import prk4_pkg::*;

    typedef enum logic [31:0] {
        S_IDLE  = 32'h0000_0001,
        S_XMUL  = 32'h0000_0002,
        S_XW    = 32'h0000_0004,
        S_MOD   = 32'h0000_0008,
        S_MODW  = 32'h0000_0010,
        S_SQ    = 32'h0000_0020,
        S_SQW   = 32'h0000_0040,
        S_HT    = 32'h0000_0080,
        S_HTW   = 32'h0000_0100,
        S_HD    = 32'h0000_0200,
        S_HDW   = 32'h0000_0400,
        S_SX    = 32'h0000_0800,
        S_SXW   = 32'h0000_1000,
        S_G     = 32'h0000_2000,
        S_GW    = 32'h0000_4000,
        S_VMUL  = 32'h0000_8000,
        S_VW    = 32'h0001_0000,
        S_QV    = 32'h0002_0000,
        S_QVW   = 32'h0004_0000,
        S_QVD   = 32'h0008_0000,
        S_QVDW  = 32'h0010_0000,
        S_WRAP  = 32'h0020_0000,
        S_WRAPW = 32'h0040_0000,
        S_QA    = 32'h0080_0000,
        S_QAW   = 32'h0100_0000,
        S_QAD   = 32'h0200_0000,
        S_QADW  = 32'h0400_0000,
        S_RED   = 32'h0800_0000,
        S_REDW  = 32'h1000_0000,
        S_FR    = 32'h2000_0000,
        S_FRW   = 32'h4000_0000,
        S_DONE  = 32'h8000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]         r_grav;
    logic [CFG_W-1:0]         r_dt;
    logic [CFG_W-1:0]         r_fric;
    logic [CFG_W-1:0]         r_lim;

    logic signed [WORD_W-1:0] r_th;
    logic signed [WORD_W-1:0] r_w;
    logic signed [WORD_W-1:0] r_mir;
    logic signed [WORD_W-1:0] r_v2;
    logic signed [WORD_W-1:0] r_v3;
    logic signed [WORD_W-1:0] r_a;
    logic signed [WORD_W-1:0] r_x;
    logic signed [SUM_W-1:0]  r_sa;
    logic signed [SUM_W-1:0]  r_sv;
    logic [MB_W-1:0]          r_m;
    logic [WORD_W-1:0]        r_x2;
    logic [MB_W-1:0]          r_t;
    logic [2:0]               r_k;
    logic [1:0]               r_call;
    logic                     r_neg;
    logic                     r_sg;
    logic                     r_ovld;
    t_out                     r_out;

    t_mul_req                 mreq;
    t_div_req                 dreq;
    logic                     mul_done;
    logic [MR_W-1:0]          mul_res;
    logic                     div_done;
    logic [DD_W-1:0]          div_quo;
    logic [DV_W-1:0]          div_rem;

    logic                     in_acc;
    logic signed [WORD_W-1:0] vsel;
    logic signed [ACC_W-1:0]  ms;
    logic signed [ACC_W-1:0]  ds;
    logic signed [WORD_W-1:0] acc_v;
    logic signed [WORD_W-1:0] new_v;
    logic [DV_W-1:0]          m1;
    logic [DV_W-1:0]          m2;
    logic                     flip;
    logic signed [ACC_W-1:0]  wrap_u;
    logic signed [DV_W:0]     mir_d;
    logic [WORD_W-1:0]        rem32;
    logic signed [WORD_W-1:0] red_v;
    logic                     over_lim;

    prk4_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    prk4_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dreq),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        case (r_call)
            2'd1:    vsel = r_w;
            2'd2:    vsel = r_v2;
            default: vsel = r_v3;
        endcase
        ms    = sgn44(mul_res, r_sg);
        ds    = sgn44(div_quo[MR_W-1:0], r_sg);
        acc_v = sat32(sgn44(mul_res, !r_neg));
        new_v = sat32(sx44(r_w) + ms);
        flip  = (div_rem >= C_PI30);
        m1    = flip ? (div_rem - C_PI30) : div_rem;
        m2    = (m1 > C_HALF_PI30) ? (C_PI30 - m1) : m1;
        wrap_u = WRAP_OFS - sx44(r_th);
        mir_d = $signed({1'b0, div_rem}) - $signed({1'b0, C_PI24});
        rem32 = WORD_W'(div_rem);
        red_v = r_neg ? $signed(-rem32) : $signed(rem32);
        over_lim = (mag32(r_th) > {1'b0, r_lim});
    end

    always_comb begin
        n_state = r_state;
        mreq    = '0;
        dreq    = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = i_in.req_type ? S_DONE : S_XMUL;
                end
            end
            S_XMUL: begin
                if (r_call == 2'd0) begin
                    n_state = S_MOD;
                end else begin
                    mreq.start = 1'b1;
                    mreq.a     = MA_W'(mag32(vsel));
                    mreq.b     = r_dt;
                    mreq.sh    = (r_call == 2'd3) ? SH_FULL : SH_HALF;
                    mreq.rnd   = 1'b1;
                    n_state    = S_XW;
                end
            end
            S_XW:    if (mul_done) n_state = S_MOD;
            S_MOD: begin
                dreq.start = 1'b1;
                dreq.num   = DD_W'(mag32(r_x)) << SIN_SH;
                dreq.den   = C_TWO_PI30;
                n_state    = S_MODW;
            end
            S_MODW:  if (div_done) n_state = S_SQ;
            S_SQ: begin
                mreq.start = 1'b1;
                mreq.a     = MA_W'(r_m);
                mreq.b     = r_m;
                mreq.sh    = SH_FULL;
                n_state    = S_SQW;
            end
            S_SQW:   if (mul_done) n_state = S_HT;
            S_HT: begin
                mreq.start = 1'b1;
                mreq.a     = MA_W'(r_x2);
                mreq.b     = r_t;
                mreq.sh    = SH_FULL;
                n_state    = S_HTW;
            end
            S_HTW:   if (mul_done) n_state = S_HD;
            S_HD: begin
                dreq.start = 1'b1;
                dreq.num   = DD_W'(mul_res);
                dreq.den   = HORNER_DIV[r_k];
                n_state    = S_HDW;
            end
            S_HDW: begin
                if (div_done) begin
                    n_state = (r_k == 3'(HORNER_N - 1)) ? S_SX : S_HT;
                end
            end
            S_SX: begin
                mreq.start = 1'b1;
                mreq.a     = MA_W'(r_m);
                mreq.b     = r_t;
                mreq.sh    = SH_FULL;
                n_state    = S_SXW;
            end
            S_SXW:   if (mul_done) n_state = S_G;
            S_G: begin
                mreq.start = 1'b1;
                mreq.a     = MA_W'(mul_res >> SIN_SH);
                mreq.b     = r_grav;
                mreq.sh    = SH_ACC;
                mreq.rnd   = 1'b1;
                n_state    = S_GW;
            end
            S_GW: begin
                if (mul_done) begin
                    n_state = (r_call == 2'd3) ? S_QV : S_VMUL;
                end
            end
            S_VMUL: begin
                mreq.start = 1'b1;
                mreq.a     = MA_W'(mag32(r_a));
                mreq.b     = r_dt;
                mreq.sh    = (r_call == 2'd2) ? SH_FULL : SH_HALF;
                mreq.rnd   = 1'b1;
                n_state    = S_VW;
            end
            S_VW:    if (mul_done) n_state = S_XMUL;
            S_QV: begin
                mreq.start = 1'b1;
                mreq.a     = mag36(r_sv);
                mreq.b     = r_dt;
                mreq.sh    = SH_FULL;
                mreq.rnd   = 1'b1;
                n_state    = S_QVW;
            end
            S_QVW:   if (mul_done) n_state = S_QVD;
            S_QVD: begin
                dreq.start = 1'b1;
                dreq.num   = DD_W'(mul_res) + C_D6_BIAS;
                dreq.den   = C_DIV6;
                n_state    = S_QVDW;
            end
            S_QVDW:  if (div_done) n_state = S_WRAP;
            S_WRAP: begin
                dreq.start = 1'b1;
                dreq.num   = wrap_u[DD_W-1:0];
                dreq.den   = C_TP;
                n_state    = S_WRAPW;
            end
            S_WRAPW: if (div_done) n_state = S_QA;
            S_QA: begin
                mreq.start = 1'b1;
                mreq.a     = mag36(r_sa);
                mreq.b     = r_dt;
                mreq.sh    = SH_FULL;
                mreq.rnd   = 1'b1;
                n_state    = S_QAW;
            end
            S_QAW:   if (mul_done) n_state = S_QAD;
            S_QAD: begin
                dreq.start = 1'b1;
                dreq.num   = DD_W'(mul_res) + C_D6_BIAS;
                dreq.den   = C_DIV6;
                n_state    = S_QADW;
            end
            S_QADW:  if (div_done) n_state = S_RED;
            S_RED: begin
                if (over_lim) begin
                    dreq.start = 1'b1;
                    dreq.num   = DD_W'(mag32(r_th));
                    dreq.den   = C_TP;
                    n_state    = S_REDW;
                end else begin
                    n_state = S_FR;
                end
            end
            S_REDW:  if (div_done) n_state = S_FR;
            S_FR: begin
                mreq.start = 1'b1;
                mreq.a     = MA_W'(mag32(r_w));
                mreq.b     = r_fric;
                mreq.sh    = SH_FULL;
                mreq.rnd   = 1'b1;
                n_state    = S_FRW;
            end
            S_FRW:   if (mul_done) n_state = S_DONE;
            S_DONE: begin
                if (!r_ovld || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_th    <= '0;
            r_w     <= '0;
            r_mir   <= '0;
            r_call  <= '0;
            r_k     <= '0;
            r_grav  <= RST_GRAV;
            r_dt    <= RST_DT;
            r_fric  <= RST_FRIC;
            r_lim   <= RST_LIMIT;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GRAV:  r_grav <= i_cfg_data;
                    REG_DT:    r_dt   <= i_cfg_data;
                    REG_FRIC:  r_fric <= i_cfg_data;
                    REG_LIMIT: r_lim  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovld && !i_out_stall) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_call <= '0;
                        if (i_in.req_type) begin
                            r_th  <= i_in.new_angle;
                            r_w   <= i_in.new_speed;
                            r_mir <= sat32(-sx44(i_in.new_angle));
                        end
                    end
                end
                S_XMUL: begin
                    if (r_call == 2'd0) begin
                        r_x <= r_th;
                    end else begin
                        r_sg <= vsel[WORD_W-1];
                    end
                end
                S_XW:   if (mul_done) r_x <= sat32(sx44(r_th) + ms);
                S_MOD:  r_neg <= r_x[WORD_W-1];
                S_MODW: begin
                    if (div_done) begin
                        r_m   <= m2[MB_W-1:0];
                        r_neg <= r_neg ^ flip;
                    end
                end
                S_SQW: begin
                    if (mul_done) begin
                        r_x2 <= mul_res[WORD_W-1:0];
                        r_t  <= C_ONE_Q30;
                        r_k  <= '0;
                    end
                end
                S_HDW: begin
                    if (div_done) begin
                        r_t <= C_ONE_Q30 - div_quo[MB_W-1:0];
                        r_k <= r_k + 3'd1;
                    end
                end
                S_GW: begin
                    if (mul_done) begin
                        r_a <= acc_v;
                        case (r_call)
                            2'd0:    r_sa <= sx36(acc_v);
                            2'd3:    r_sa <= r_sa + sx36(acc_v);
                            default: r_sa <= r_sa + sx36(acc_v) + sx36(acc_v);
                        endcase
                    end
                end
                S_VMUL: r_sg <= r_a[WORD_W-1];
                S_VW: begin
                    if (mul_done) begin
                        case (r_call)
                            2'd0: begin
                                r_v2 <= new_v;
                                r_sv <= sx36(r_w) + sx36(new_v) + sx36(new_v);
                            end
                            2'd1: begin
                                r_v3 <= new_v;
                                r_sv <= r_sv + sx36(new_v) + sx36(new_v);
                            end
                            default: r_sv <= r_sv + sx36(new_v);
                        endcase
                        r_call <= r_call + 2'd1;
                    end
                end
                S_QV:    r_sg <= r_sv[SUM_W-1];
                S_QVDW:  if (div_done) r_th <= sat32(sx44(r_th) + ds);
                S_WRAPW: if (div_done) r_mir <= mir_d[WORD_W-1:0];
                S_QA:    r_sg <= r_sa[SUM_W-1];
                S_QADW:  if (div_done) r_w <= sat32(sx44(r_w) + ds);
                S_RED:   r_neg <= r_th[WORD_W-1];
                S_REDW:  if (div_done) r_th <= red_v;
                S_FR:    r_sg <= r_w[WORD_W-1];
                S_FRW:   if (mul_done) r_w <= sat32(ms);
                S_DONE: begin
                    if (!r_ovld || !i_out_stall) begin
                        r_out.angle_raw      <= r_th;
                        r_out.angle_mirrored <= r_mir;
                        r_out.speed          <= r_w;
                        r_ovld               <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/prk4_check.sv */
// Port-level checker for the pendulum RK4 step block, bound to the top level.
`include "pendulum_rk4_step_assert.svh"

module prk4_check (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_stall,
    input logic            i_out_valid,
    input logic            i_out_stall,
    input prk4_pkg::t_out  i_out
);
    import prk4_pkg::*;

    // one item in flight: accepting closes the input side
    `PRK4_AST_NXT(a_busy_after_accept, i_in_valid && !i_in_stall, i_in_stall, "input open after accept")

    // a new result only appears from a busy block
    `PRK4_AST_NOW(a_result_from_work, $rose(i_out_valid), $past(i_in_stall), "result without item")

    `PRK4_AST_NXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out), "stalled item changed")

endmodule

bind pendulum_rk4_step prk4_check u_prk4_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

/* bench/pendulum_rk4_step_checker.sv */
// Checker for the pendulum RK4 step block: predicts each result and compares it.
`timescale 1ns / 1ps
module pendulum_rk4_step_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  prk4_pkg::t_in      i_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  prk4_pkg::t_out     i_out,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    import prk4_pkg::*;

    localparam longint W_HI = 64'sd2147483647;
    localparam longint W_LO = -64'sd2147483648;
    localparam logic [63:0] CAP62 = 64'd1 << 62;

    longint grav, dt, fric, lim;
    longint theta, omega, theta_mir;
    t_out   expected_q[$];

    function automatic longint clip(longint v);
        return v > W_HI ? W_HI : (v < W_LO ? W_LO : v);
    endfunction

    function automatic logic [63:0] absval(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_cap(logic [63:0] m, bit neg);
        if (m > CAP62) m = CAP62;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] pi_fix(int f);
        return (PI_Q62 + (64'd1 << (61 - f))) >> (62 - f);
    endfunction

    function automatic longint fxmul(longint a, longint b, int s);
        logic [127:0] p;
        p = {64'd0, absval(a)} * {64'd0, absval(b)};
        p = (p + (128'd1 << (s - 1))) >> s;
        if (p > {64'd0, CAP62}) p = {64'd0, CAP62};
        return signed_cap(p[63:0], (a < 0) != (b < 0));
    endfunction

    function automatic longint div_six(longint v);
        return signed_cap((absval(v) + 3) / 6, v < 0);
    endfunction

    function automatic longint sine_fix(longint x);
        logic [63:0] m, x2, t, half_pi, pi30;
        logic [63:0] k[5];
        bit neg;
        k = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        neg = x < 0;
        pi30 = pi_fix(30);
        half_pi = pi_fix(29);
        m = (absval(x) << 6) % pi_fix(31);
        if (m >= pi30) begin
            m = m - pi30;
            neg = !neg;
        end
        if (m > half_pi) m = pi30 - m;
        x2 = (m * m) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 5; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / k[i];
        return signed_cap(((m * t) >> 30) >> 6, neg);
    endfunction

    function automatic longint accel_of(longint th);
        return clip(-fxmul(grav, sine_fix(th), 24));
    endfunction

    function automatic longint wrap_half_turn(longint v);
        longint p, tp, r;
        p = longint'(pi_fix(24));
        tp = longint'(pi_fix(25));
        r = (v + p) % tp;
        if (r < 0) r += tp;
        return r - p;
    endfunction

    function automatic void rk4_advance();
        longint v1, v2, v3, v4, a1, a2, a3, a4;
        v1 = omega;
        a1 = accel_of(theta);
        v2 = clip(omega + fxmul(a1, dt, 31));
        a2 = accel_of(clip(theta + fxmul(v1, dt, 31)));
        v3 = clip(omega + fxmul(a2, dt, 31));
        a3 = accel_of(clip(theta + fxmul(v2, dt, 31)));
        v4 = clip(omega + fxmul(a3, dt, 30));
        a4 = accel_of(clip(theta + fxmul(v3, dt, 30)));
        theta = clip(theta + div_six(fxmul(v1 + 2 * v2 + 2 * v3 + v4, dt, 30)));
        theta_mir = clip(wrap_half_turn(-theta));
        omega = clip(omega + div_six(fxmul(a1 + 2 * a2 + 2 * a3 + a4, dt, 30)));
        if (absval(theta) > 64'(lim)) theta = signed_cap(absval(theta) % pi_fix(25), theta < 0);
        omega = clip(fxmul(omega, fric, 30));
    endfunction

    always @(posedge i_clk) begin
        t_out e;
        int   errs;
        if (!i_rst_n) begin
            grav <= RST_GRAV;
            dt <= RST_DT;
            fric <= RST_FRIC;
            lim <= RST_LIMIT;
            theta = 0;
            omega = 0;
            theta_mir = 0;
            expected_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            errs = 0;
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_GRAV:  grav <= i_cfg_data;
                    REG_DT:    dt <= i_cfg_data;
                    REG_FRIC:  fric <= i_cfg_data;
                    REG_LIMIT: lim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in.req_type) begin
                    theta = longint'(i_in.new_angle);
                    omega = longint'(i_in.new_speed);
                    theta_mir = clip(-theta);
                end else begin
                    rk4_advance();
                end
                e.angle_raw = theta[31:0];
                e.angle_mirrored = theta_mir[31:0];
                e.speed = omega[31:0];
                expected_q.push_back(e);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected item %h", $time, i_out);
                    errs++;
                end else begin
                    e = expected_q.pop_front();
                    if (e.angle_raw !== i_out.angle_raw) begin
                        $display("%0t angle_raw exp %h got %h", $time, e.angle_raw,
                                 i_out.angle_raw);
                        errs++;
                    end
                    if (e.angle_mirrored !== i_out.angle_mirrored) begin
                        $display("%0t angle_mirrored exp %h got %h", $time,
                                 e.angle_mirrored, i_out.angle_mirrored);
                        errs++;
                    end
                    if (e.speed !== i_out.speed) begin
                        $display("%0t speed exp %h got %h", $time, e.speed, i_out.speed);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
            o_pending <= expected_q.size();
        end
    end
endmodule

/* bench/pendulum_rk4_step_tb.sv */
// Top of the pendulum RK4 step testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module pendulum_rk4_step_tb;
    import prk4_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_stall;
    t_in            i_in = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    t_out           o_out;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index = '0;
    logic [30:0]    i_cfg_data = '0;
    int             fail_count;
    int             pending;
    bit             jitter_on = 1'b1;
    longint         cycles = 0;
    int             steps_left;

    always #10 i_clk = ~i_clk;

    pendulum_rk4_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    pendulum_rk4_step_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out(o_out),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        i_out_stall <= jitter_on && ($urandom_range(99) < 37);
    end

    task automatic push_item(input logic kind, input logic [31:0] ang, input logic [31:0] spd);
        bit taken;
        if (jitter_on && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{req_type: kind, new_angle: ang, new_speed: spd};
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [30:0] val);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [30:0] g, input logic [30:0] d,
                            input logic [30:0] f, input logic [30:0] l);
        write_reg(REG_GRAV, g);
        write_reg(REG_DT, d);
        write_reg(REG_FRIC, f);
        write_reg(REG_LIMIT, l);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_items(input int count);
        logic [31:0] a, s;
        for (int n = 0; n < count; n++) begin
            jitter_on = !(n >= count / 3 && n < count / 3 + 60);
            if (steps_left == 0 || $urandom_range(99) < 8) begin
                if ($urandom_range(1)) begin
                    a = 32'($signed($urandom_range(0, 32'd200_000_000)) - 100_000_000);
                    s = 32'($signed($urandom_range(0, 32'd300_000_000)) - 150_000_000);
                end else begin
                    a = $urandom;
                    s = $urandom;
                end
                push_item(1'b1, a, s);
                steps_left = $urandom_range(1, 8);
            end else begin
                push_item(1'b0, $urandom, $urandom);
                steps_left--;
            end
        end
        jitter_on = 1'b1;
    endtask

    initial begin
        steps_left = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_item(1'b0, 32'h0, 32'h0);
        push_item(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_item(1'b0, 32'h0, 32'h0);
        push_item(1'b1, 32'h8000_0000, 32'h8000_0000);
        push_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(1'b1, 32'h0324_3F6B, 32'h0);
        push_item(1'b0, 32'h0, 32'h0);
        push_item(1'b1, 32'h6400_0001, 32'h0100_0000);
        push_item(1'b0, 32'h0, 32'h0);
        push_item(1'b1, 32'h9BFF_FFFF, 32'hF000_0000);
        push_item(1'b0, 32'h0, 32'h0);
        drain();

        set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        push_item(1'b1, 32'h0100_0000, 32'h7FFF_FFFF);
        push_item(1'b0, 32'h0, 32'h0);
        push_item(1'b0, 32'h0, 32'h0);
        drain();
        set_regs(31'd0, 31'd0, 31'd0, 31'd0);
        push_item(1'b1, 32'h0400_0000, 32'h0200_0000);
        push_item(1'b0, 32'h0, 32'h0);
        push_item(1'b1, 32'hFA00_0000, 32'h8000_0000);
        push_item(1'b0, 32'h0, 32'h0);
        drain();

        set_regs(RST_GRAV, RST_DT, RST_FRIC, RST_LIMIT);
        random_items(500);
        drain();
        set_regs(31'd1_000_000_000, 31'd1_073_741_824, 31'd1_000_000_000, 31'd0);
        random_items(250);
        drain();
        set_regs(31'd0, 31'd1, 31'd1_073_741_824, 31'h7FFF_FFFF);
        random_items(200);
        drain();
        set_regs(31'd400_000_000, 31'd0, 31'd900_000_000, 31'd100_000_000);
        random_items(200);
        drain();
        set_regs(31'($urandom), 31'($urandom_range(1, 200_000_000)),
                 31'($urandom_range(900_000_000, 1_073_741_824)),
                 31'($urandom_range(0, 2_000_000_000)));
        random_items(550);
        drain();
        repeat (40) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/prk4_pkg.sv
rtl/prk4_mul.sv
rtl/prk4_div.sv
rtl/pendulum_rk4_step.sv
rtl/prk4_check.sv
bench/pendulum_rk4_step_checker.sv
bench/pendulum_rk4_step_tb.sv
